// ===== rtl/lzd_pkg.sv =====
package lzd_pkg;

   localparam int AddrW           = 16;
   localparam int WinDepth        = 1 << AddrW;
   localparam int MaxRun          = 33;
   localparam int RunW            = 6;
   localparam int PreW            = 3;
   localparam int PreMin          = 1;
   localparam int PreMax          = 5;
   localparam int MinMatchDefault = 2;
   localparam logic [PreW-1:0] PreBitsReset = 3'd4;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_ITEM,
      PH_CODE_HI
   } phase_type;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_CODE,
      CMD_CLR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  data;
      logic         eos;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_COPY
   } back_state_type;

   // saturate the length field width into its legal range
   function automatic logic [PreW-1:0] eff_pre(input logic [PreW-1:0] p);
      logic [PreW-1:0] r;
      r = p;
      if (p < PreW'(PreMin)) begin
         r = PreW'(PreMin);
      end else if (p > PreW'(PreMax)) begin
         r = PreW'(PreMax);
      end
      return r;
   endfunction

endpackage

// ===== rtl/lzd_front.sv =====
module lzd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              fifo_full,
   output logic              fifo_push,
   output lzd_pkg::cmd_type  fifo_cmd
);

   lzd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         flags_ff, flags_in;
   logic [2:0]         idx_ff, idx_in;
   logic [7:0]         low_ff, low_in;
   logic               accept;
   logic               flag_bit;

   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && !fifo_full;
   assign flag_bit   = flags_ff[3'd7 - idx_ff];

   always_comb begin
      phase_in      = phase_ff;
      flags_in      = flags_ff;
      idx_in        = idx_ff;
      low_in        = low_ff;
      fifo_push     = 1'b0;
      fifo_cmd.kind = lzd_pkg::CMD_CLR;
      fifo_cmd.data = {8'd0, req_tdata};
      fifo_cmd.eos  = req_tlast;
      if (accept) begin
         unique case (phase_ff)
            lzd_pkg::PH_ITEM: begin
               if (flag_bit) begin
                  fifo_push     = 1'b1;
                  fifo_cmd.kind = lzd_pkg::CMD_LIT;
                  idx_in        = idx_ff + 3'd1;
                  phase_in      = (idx_ff == 3'd7) ? lzd_pkg::PH_FLAG : lzd_pkg::PH_ITEM;
               end else begin
                  low_in    = req_tdata;
                  phase_in  = lzd_pkg::PH_CODE_HI;
                  fifo_push = req_tlast;
               end
            end
            lzd_pkg::PH_CODE_HI: begin
               fifo_push     = 1'b1;
               fifo_cmd.kind = lzd_pkg::CMD_CODE;
               fifo_cmd.data = {req_tdata, low_ff};
               idx_in        = idx_ff + 3'd1;
               phase_in      = (idx_ff == 3'd7) ? lzd_pkg::PH_FLAG : lzd_pkg::PH_ITEM;
            end
            default: begin
               flags_in  = req_tdata;
               idx_in    = 3'd0;
               phase_in  = lzd_pkg::PH_ITEM;
               fifo_push = req_tlast;
            end
         endcase
         if (req_tlast) begin
            phase_in = lzd_pkg::PH_FLAG;
            flags_in = 8'd0;
            idx_in   = 3'd0;
            low_in   = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lzd_pkg::PH_FLAG;
         flags_ff <= 8'd0;
         idx_ff   <= 3'd0;
         low_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         idx_ff   <= idx_in;
         low_ff   <= low_in;
      end
   end

endmodule

// ===== rtl/lzd_cmd_fifo.sv =====
module lzd_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lzd_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output lzd_pkg::cmd_type  head
);

   lzd_pkg::cmd_type slot_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in    = do_push ? !wr_ff : wr_ff;
      rd_in    = do_pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/lzd_back.sv =====
module lzd_back #(
   parameter int MIN_MATCH = lzd_pkg::MinMatchDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lzd_pkg::PreW-1:0]   pre_bits,
   input  logic                       cmd_valid,
   input  lzd_pkg::cmd_type           cmd,
   output logic                       cmd_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int AW = lzd_pkg::AddrW;
   localparam int RW = lzd_pkg::RunW;

   lzd_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] held_ff, held_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [RW-1:0] remain_ff, remain_in;
   logic          eos_ff, eos_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [7:0]    mem [lzd_pkg::WinDepth];
   logic [7:0]    rd_ff;
   logic          byp_ff;
   logic [7:0]    bypd_ff;
   logic          we;
   logic [7:0]    wdata;
   logic [AW-1:0] raddr;

   logic [lzd_pkg::PreW-1:0] p;
   logic [AW-1:0] offset;
   logic [AW-1:0] len_field;
   logic [RW:0]   len_wide;
   logic [RW-1:0] len_run;
   logic [AW:0]   limit_wide;
   logic [AW-1:0] limit;
   logic [AW-1:0] held_inc;
   logic [AW-1:0] held_inc_cl;
   logic [AW-1:0] held_cl;
   logic [AW-1:0] start;
   logic [7:0]    cpy_data;
   logic          out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      p           = lzd_pkg::eff_pre(pre_bits);
      offset      = cmd.data >> p;
      len_field   = cmd.data & ((AW'(1) << p) - AW'(1));
      len_wide    = (RW+1)'(len_field[4:0]) + (RW+1)'(MIN_MATCH);
      len_run     = (len_wide > (RW+1)'(lzd_pkg::MaxRun)) ? RW'(lzd_pkg::MaxRun)
                                                          : len_wide[RW-1:0];
      limit_wide  = ((AW+1)'(1) << (5'(AW) - 5'(p))) + (AW+1)'(MIN_MATCH) - (AW+1)'(1);
      limit       = limit_wide[AW-1:0];
      held_inc    = held_ff + AW'(1);
      held_inc_cl = (held_inc > limit) ? limit : held_inc;
      held_cl     = (held_ff > limit) ? limit : held_ff;
      start       = wp_ff - held_ff + offset;
      cpy_data    = byp_ff ? bypd_ff : rd_ff;
      out_free    = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      held_in      = held_ff;
      ptr_in       = ptr_ff;
      remain_in    = remain_ff;
      eos_in       = eos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      we           = 1'b0;
      wdata        = cpy_data;
      raddr        = ptr_ff;
      cmd_pop      = 1'b0;
      unique case (state_ff)
         lzd_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  lzd_pkg::CMD_LIT: begin
                     if (out_free) begin
                        cmd_pop      = 1'b1;
                        we           = 1'b1;
                        wdata        = cmd.data[7:0];
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = cmd.data[7:0];
                        rsp_last_in  = 1'b1;
                        wp_in        = wp_ff + AW'(1);
                        held_in      = held_inc_cl;
                        if (cmd.eos) begin
                           wp_in   = '0;
                           held_in = '0;
                        end
                     end
                  end
                  lzd_pkg::CMD_CODE: begin
                     cmd_pop = 1'b1;
                     if (offset < held_ff) begin
                        raddr     = start;
                        ptr_in    = start;
                        remain_in = len_run;
                        eos_in    = cmd.eos;
                        state_in  = lzd_pkg::BK_COPY;
                     end else begin
                        held_in = held_cl;
                        if (cmd.eos) begin
                           wp_in   = '0;
                           held_in = '0;
                        end
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                     wp_in   = '0;
                     held_in = '0;
                  end
               endcase
            end
         end
         lzd_pkg::BK_COPY: begin
            if (out_free) begin
               we           = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = cpy_data;
               rsp_last_in  = (remain_ff == RW'(1));
               wp_in        = wp_ff + AW'(1);
               ptr_in       = ptr_ff + AW'(1);
               raddr        = ptr_ff + AW'(1);
               remain_in    = remain_ff - RW'(1);
               held_in      = held_inc;
               if (remain_ff == RW'(1)) begin
                  held_in  = held_inc_cl;
                  state_in = lzd_pkg::BK_IDLE;
                  if (eos_ff) begin
                     wp_in   = '0;
                     held_in = '0;
                  end
               end
            end
         end
         default: begin
            state_in = lzd_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzd_pkg::BK_IDLE;
         wp_ff        <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      remain_ff   <= remain_in;
      eos_ff      <= eos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // window store with write-to-read forwarding for overlapping copies
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wp_ff] <= wdata;
      end
      rd_ff   <= mem[raddr];
      byp_ff  <= we && (wp_ff == raddr);
      bypd_ff <= wdata;
   end

endmodule

// ===== rtl/lzss_decoder.sv =====
// lzss decoder: compressed words in on req_*, decompressed words out on rsp_*.
// req_tdata carries one compressed byte, req_tlast marks the last byte of a
// stream; after it the window and the group state are cleared. rsp_tdata
// carries one output byte and rsp_tlast marks the final byte produced by one
// input word. csr_we/csr_wdata write the length field width (pre_bits); write
// it only while the block is idle.
// The front end classifies words (flag, literal, code halves) and passes
// literals, codes and end-of-stream clears through a two-entry queue to the
// back end, which owns the 64k window memory. Flag bytes and code low bytes
// are absorbed by the front end. The back end writes and sends out a literal
// directly; a match issues the window read at its start, then copies 2 to 33
// bytes through the window memory's single read port and takes no new command
// until done. A literal's byte passes the queue and the output register; the
// first byte of a match passes the queue, window read and output registers.
// When rsp_tready is low the output register holds its word and the copy
// stalls in place; the queue fills and req_tready drops.
// Reset clears state, pointers, counts and output valid and empties the window;
// copy registers, output data and memory are left and need no clearing pass.
module lzss_decoder #(
   parameter int MIN_MATCH = lzd_pkg::MinMatchDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // in_byte
   input  logic                      req_tlast,   // end_of_stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // out_byte
   output logic                      rsp_tlast,   // last_of_run
   input  logic                      csr_we,
   input  logic [lzd_pkg::PreW-1:0]  csr_wdata
);

   logic [lzd_pkg::PreW-1:0] pre_bits_ff, pre_bits_in;
   logic                     fifo_full;
   logic                     fifo_push;
   lzd_pkg::cmd_type         push_cmd;
   logic                     fifo_pop;
   logic                     fifo_not_empty;
   lzd_pkg::cmd_type         head_cmd;

   assign pre_bits_in = csr_we ? csr_wdata : pre_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_bits_ff <= lzd_pkg::PreBitsReset;
      end else begin
         pre_bits_ff <= pre_bits_in;
      end
   end

   lzd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .fifo_push  (fifo_push),
      .fifo_cmd   (push_cmd)
   );

   lzd_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_cmd  (push_cmd),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .not_empty (fifo_not_empty),
      .head      (head_cmd)
   );

   lzd_back #(
      .MIN_MATCH (MIN_MATCH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pre_bits   (pre_bits_ff),
      .cmd_valid  (fifo_not_empty),
      .cmd        (head_cmd),
      .cmd_pop    (fifo_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_full)
      else $error("command pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> fifo_not_empty)
      else $error("command popped from empty queue");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !fifo_not_empty)
      else $error("output or queue not empty after reset");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int MinMatch = lzd_pkg::MinMatchDefault;

   typedef struct {
      logic [7:0] data;
      logic       eos;
   } comp_byte_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } plain_byte_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;   // in_byte
   logic                     req_tlast;   // end_of_stream
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [7:0]               rsp_tdata;   // out_byte
   logic                     rsp_tlast;   // last_of_run
   logic                     csr_we;
   logic [lzd_pkg::PreW-1:0] csr_wdata;

   comp_byte_type  pending_bytes[$];
   plain_byte_type expected_bytes[$];
   int             queued_count   = 0;
   int             accepted_count = 0;
   int             errors         = 0;
   bit             req_taken      = 0;
   int             req_wait       = 0;
   int             rsp_wait       = 0;
   bit             idle_on        = 1;
   int             gen_held       = 0;

   // decoder shadow state
   logic [7:0]               win_mem [0:lzd_pkg::WinDepth-1];
   logic [15:0]              win_wp;
   int                       win_held;
   logic [7:0]               grp_flags;
   int                       grp_idx;
   logic [7:0]               code_lo;
   lzd_pkg::phase_type       dec_phase;
   logic [lzd_pkg::PreW-1:0] cfg_pre;

   lzss_decoder #(
      .MIN_MATCH(MinMatch)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 0;
   end

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic int eff_width(input logic [lzd_pkg::PreW-1:0] p);
      int r;
      r = int'(p);
      if (r < lzd_pkg::PreMin) begin
         r = lzd_pkg::PreMin;
      end else if (r > lzd_pkg::PreMax) begin
         r = lzd_pkg::PreMax;
      end
      return r;
   endfunction

   function automatic int window_limit(input logic [lzd_pkg::PreW-1:0] p);
      return (1 << (16 - eff_width(p))) - 1 + MinMatch;
   endfunction

   task automatic report_error(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic clear_stream();
      win_wp    = '0;
      win_held  = 0;
      grp_flags = '0;
      grp_idx   = 0;
      code_lo   = '0;
      dec_phase = lzd_pkg::PH_FLAG;
   endtask

   task automatic append_window(input logic [7:0] v);
      win_mem[win_wp] = v;
      win_wp          = win_wp + 16'd1;
      win_held++;
   endtask

   task automatic finish_item();
      if (win_held > window_limit(cfg_pre)) begin
         win_held = window_limit(cfg_pre);
      end
      grp_idx++;
      dec_phase = (grp_idx >= 8) ? lzd_pkg::PH_FLAG : lzd_pkg::PH_ITEM;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eos);
      logic [7:0]     run_bytes[$];
      logic [15:0]    code;
      logic [15:0]    oldest;
      logic [7:0]     v;
      int             p;
      int             off;
      int             len;
      plain_byte_type w;
      case (dec_phase)
         lzd_pkg::PH_ITEM: begin
            if (grp_flags[3'(7 - grp_idx)]) begin
               append_window(b);
               run_bytes.insert(run_bytes.size(), b);
               finish_item();
            end else begin
               code_lo   = b;
               dec_phase = lzd_pkg::PH_CODE_HI;
            end
         end
         lzd_pkg::PH_CODE_HI: begin
            p    = eff_width(cfg_pre);
            code = {b, code_lo};
            off  = int'(code >> p);
            len  = int'(code & 16'((1 << p) - 1)) + MinMatch;
            if (len > lzd_pkg::MaxRun) begin
               len = lzd_pkg::MaxRun;
            end
            if (off < win_held) begin
               oldest = win_wp - 16'(win_held);
               for (int j = 0; j < len; j++) begin
                  v = win_mem[16'(oldest + 16'(off) + 16'(j))];
                  append_window(v);
                  run_bytes.insert(run_bytes.size(), v);
               end
            end
            finish_item();
         end
         default: begin
            grp_flags = b;
            grp_idx   = 0;
            dec_phase = lzd_pkg::PH_ITEM;
         end
      endcase
      foreach (run_bytes[i]) begin
         w.data = run_bytes[i];
         w.last = (i == run_bytes.size() - 1);
         expected_bytes.insert(expected_bytes.size(), w);
      end
      if (eos) begin
         clear_stream();
      end
   endtask

   // accept side: prediction, csr shadow and response check
   always @(posedge clock) begin
      plain_byte_type w;
      if (reset) begin
         cfg_pre = lzd_pkg::PreBitsReset;
         clear_stream();
      end else begin
         if (csr_we) begin
            cfg_pre = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            accepted_count++;
            req_taken = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_error($sformatf("unexpected word %02h", rsp_tdata));
            end else begin
               w = expected_bytes.pop_front();
               if (rsp_tdata !== w.data) begin
                  report_error($sformatf("tdata %02h, want %02h", rsp_tdata, w.data));
               end
               if (rsp_tlast !== w.last) begin
                  report_error($sformatf("tlast %b, want %b", rsp_tlast, w.last));
               end
            end
            rsp_wait = idle_on ? $urandom_range(0, 10) : 0;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      comp_byte_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 0;
         if (req_wait > 0) begin
            req_tvalid <= 1'b0;
            req_wait--;
         end else if (pending_bytes.size() > 0) begin
            it = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.data;
            req_tlast  <= it.eos;
            req_wait = idle_on ? $urandom_range(0, 10) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic eos);
      comp_byte_type it;
      it.data = b;
      it.eos  = eos;
      pending_bytes.insert(pending_bytes.size(), it);
      queued_count++;
   endtask

   task automatic wait_idle();
      while (!(accepted_count == queued_count && expected_bytes.size() == 0)) begin
         @(negedge clock);
      end
      repeat (50) @(negedge clock);
   endtask

   task automatic write_width(input logic [lzd_pkg::PreW-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic gen_noise(input int n);
      for (int i = 0; i < n; i++) begin
         queue_byte(8'($urandom), ($urandom_range(0, 7) == 0) || (i == n - 1));
      end
   endtask

   // stream with mostly in-window offsets; its end may be cut short or padded
   task automatic gen_stream(input int n);
      comp_byte_type sq[$];
      comp_byte_type it;
      logic [7:0]    flags;
      logic [15:0]   code;
      int            left;
      int            p;
      int            maxoff;
      int            off;
      int            lf;
      bit            last_hi;
      p        = eff_width(cfg_pre);
      maxoff   = (1 << (16 - p)) - 1;
      gen_held = 0;
      left     = n;
      last_hi  = 0;
      it.eos   = 1'b0;
      while (left > 0) begin
         flags   = 8'($urandom);
         it.data = flags;
         sq.insert(sq.size(), it);
         left--;
         last_hi = 0;
         for (int i = 0; i < 8 && left > 0; i++) begin
            if (flags[3'(7 - i)]) begin
               it.data = 8'($urandom);
               sq.insert(sq.size(), it);
               gen_held++;
               left--;
               last_hi = 0;
            end else begin
               if (gen_held == 0 || $urandom_range(0, 9) == 0) begin
                  off = $urandom_range(0, maxoff);
               end else begin
                  off = $urandom_range(0, (gen_held - 1 < maxoff) ? gen_held - 1 : maxoff);
               end
               lf      = $urandom_range(0, (1 << p) - 1);
               code    = 16'((off << p) | lf);
               it.data = code[7:0];
               sq.insert(sq.size(), it);
               it.data = code[15:8];
               sq.insert(sq.size(), it);
               left -= 2;
               last_hi = 1;
               if (off < gen_held) begin
                  gen_held += lf + MinMatch;
               end
            end
            if (gen_held > window_limit(cfg_pre)) begin
               gen_held = window_limit(cfg_pre);
            end
         end
      end
      if (last_hi && $urandom_range(0, 3) == 0) begin
         void'(sq.pop_back());
      end else if ($urandom_range(0, 5) == 0) begin
         it.data = 8'($urandom);
         sq.insert(sq.size(), it);
      end
      it     = sq.pop_back();
      it.eos = 1'b1;
      sq.insert(sq.size(), it);
      foreach (sq[i]) begin
         queue_byte(sq[i].data, sq[i].eos);
      end
   endtask

   initial begin
      int pre_plan [10];
      int budget;
      int n;
      pre_plan   = '{1, 5, 3, 0, 7, 2, 5, 1, 4, 6};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset width of 4
      queue_byte(8'hC0, 0);
      queue_byte(8'h00, 0);
      queue_byte(8'hFF, 0);
      queue_byte(8'h0F, 0);   // longest copy, overlapping
      queue_byte(8'h00, 0);
      queue_byte(8'h10, 0);   // shortest copy
      queue_byte(8'h00, 0);
      queue_byte(8'hF0, 0);   // offset past window, dropped
      queue_byte(8'hFF, 0);
      queue_byte(8'h41, 0);   // newest held byte, offset one below the held count
      queue_byte(8'h01, 0);
      queue_byte(8'h00, 0);
      queue_byte(8'h00, 0);
      queue_byte(8'h55, 1);   // lone code low byte at end
      queue_byte(8'hAA, 1);   // flag byte at end
      queue_byte(8'hFF, 0);
      queue_byte(8'h12, 0);
      queue_byte(8'h34, 1);   // literal at end
      queue_byte(8'h80, 0);
      queue_byte(8'hA5, 0);
      queue_byte(8'h00, 0);
      queue_byte(8'h00, 1);   // code at end
      queue_byte(8'h80, 0);
      queue_byte(8'h5A, 0);
      queue_byte(8'h10, 0);   // offset equal to held count
      queue_byte(8'h00, 1);
      wait_idle();

      foreach (pre_plan[k]) begin
         idle_on = ($urandom_range(0, 3) != 0);
         write_width(lzd_pkg::PreW'(pre_plan[k]));
         budget = 45;
         while (budget > 0) begin
            n = $urandom_range(6, 40);
            if (n > budget) begin
               n = budget;
            end
            if ($urandom_range(0, 5) == 0) begin
               gen_noise(n);
            end else begin
               gen_stream(n);
            end
            budget -= n;
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
